### hdl/cga_tdc_pkg.sv
// ============================================================================
// cga_tdc_pkg
// Shared codes, constants and the palette for the text display controller.
// ============================================================================
package cga_tdc_pkg;

    // command codes
    localparam logic [3:0] CMD_MODE       = 4'd0;
    localparam logic [3:0] CMD_COLOUR     = 4'd1;
    localparam logic [3:0] CMD_CRTC_INDEX = 4'd2;
    localparam logic [3:0] CMD_CRTC_DATA  = 4'd3;
    localparam logic [3:0] CMD_STATUS     = 4'd4;
    localparam logic [3:0] CMD_HRT_ON     = 4'd5;
    localparam logic [3:0] CMD_HRT_OFF    = 4'd6;
    localparam logic [3:0] CMD_VRT_ON     = 4'd7;
    localparam logic [3:0] CMD_VRT_OFF    = 4'd8;
    localparam logic [3:0] CMD_FRAME      = 4'd9;
    localparam logic [3:0] CMD_CELL       = 4'd10;

    localparam logic [19:0] VIDEO_BASE    = 20'hB8000;
    localparam logic [7:0]  CURSOR_GLYPH  = 8'd219;
    localparam logic [3:0]  CURSOR_FG     = 4'hF;
    localparam logic [10:0] BLINK_PERIOD  = 11'd1000;
    localparam logic [9:0]  BLINK_ON      = 10'd500;
    localparam logic [6:0]  COLS_WIDE     = 7'd80;
    localparam logic [6:0]  COLS_NARROW   = 7'd40;
    localparam logic [6:0]  TEXT_ROWS     = 7'd25;
    localparam int          CRTC_LOC_HI   = 14;
    localparam int          CRTC_LOC_LO   = 15;
    localparam logic [7:0]  STAT_HRT      = 8'h01;
    localparam logic [7:0]  STAT_VRT      = 8'h08;

    // request to the cursor / blink divider
    typedef struct packed {
        logic        start;
        logic [15:0] loc;
        logic        eighty;
        logic [31:0] time_ms;
    } div_req_t;

    // divider results, held once done has pulsed
    typedef struct packed {
        logic        done;
        logic [15:0] quot;
        logic [6:0]  rem;
        logic [9:0]  tmod;
    } div_res_t;

    function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
        logic [23:0] rgb;
        begin
            case (idx)
                4'd0:    rgb = 24'h000000;
                4'd1:    rgb = 24'h0000AA;
                4'd2:    rgb = 24'h00AA00;
                4'd3:    rgb = 24'h00AAAA;
                4'd4:    rgb = 24'hAA0000;
                4'd5:    rgb = 24'hAA00AA;
                4'd6:    rgb = 24'hAA5500;
                4'd7:    rgb = 24'hAAAAAA;
                4'd8:    rgb = 24'h555555;
                4'd9:    rgb = 24'h5555FF;
                4'd10:   rgb = 24'h55FF55;
                4'd11:   rgb = 24'h55FFFF;
                4'd12:   rgb = 24'hFF5555;
                4'd13:   rgb = 24'hFF55FF;
                4'd14:   rgb = 24'hFFFF55;
                default: rgb = 24'hFFFFFF;
            endcase
            return rgb;
        end
    endfunction

endpackage

### hdl/cga_tdc_if.sv
// ============================================================================
// cga_tdc_if
// Valid/ready channels: command requests in, result requests out.
// ============================================================================
interface cga_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  command;
    logic [7:0]  data;
    logic [4:0]  row;
    logic [6:0]  column;
    logic [7:0]  character;
    logic [7:0]  attribute;
    logic [31:0] time_ms;

    modport source (output valid, command, data, row, column, character, attribute,
                    time_ms, input ready);
    modport sink   (input valid, command, data, row, column, character, attribute,
                    time_ms, output ready);
endinterface

interface cga_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic [19:0] char_address;
    logic        draw;
    logic [7:0]  glyph;
    logic [3:0]  fg_color;
    logic [3:0]  bg_color;
    logic [23:0] color_rgb;
    logic [9:0]  pixel_x;
    logic [7:0]  pixel_y;

    modport source (output valid, read_data, char_address, draw, glyph, fg_color,
                    bg_color, color_rgb, pixel_x, pixel_y, input ready);
    modport sink   (input valid, read_data, char_address, draw, glyph, fg_color,
                    bg_color, color_rgb, pixel_x, pixel_y, output ready);
endinterface

### hdl/cga_tdc_crtc_ram.sv
// ============================================================================
// cga_tdc_crtc_ram
// CRTC register file: one write and one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ============================================================================
module cga_tdc_crtc_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [7:0]       rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : 8'd0;

endmodule

### hdl/cga_tdc_div.sv
// ============================================================================
// cga_tdc_div
// Iterative unit: cursor location / column count (one bit a cycle) and
// time mod 1000 (two bits a cycle), both in the same pass.
// ============================================================================
module cga_tdc_div
    import cga_tdc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_res_t res
);

    logic        busy_reg;
    logic        done_reg;
    logic [3:0]  cnt_reg;
    logic [15:0] loc_reg;
    logic [6:0]  rem_reg;
    logic [6:0]  cols_reg;
    logic [31:0] time_reg;
    logic [9:0]  tmod_reg;

    logic [7:0]  r8;
    logic        ge;
    logic [6:0]  rem_next;
    logic [15:0] loc_next;
    logic [10:0] t1;
    logic [9:0]  t1r;
    logic [10:0] t2;
    logic [9:0]  tmod_next;

    always_comb
    begin
        r8       = {rem_reg, loc_reg[15]};
        ge       = (r8 >= {1'b0, cols_reg});
        rem_next = ge ? 7'(r8 - {1'b0, cols_reg}) : r8[6:0];
        loc_next = {loc_reg[14:0], ge};

        t1        = {tmod_reg, time_reg[31]};
        t1r       = (t1 >= BLINK_PERIOD) ? 10'(t1 - BLINK_PERIOD) : t1[9:0];
        t2        = {t1r, time_reg[30]};
        tmod_next = (t2 >= BLINK_PERIOD) ? 10'(t2 - BLINK_PERIOD) : t2[9:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            loc_reg  <= req.loc;
            rem_reg  <= '0;
            cols_reg <= req.eighty ? COLS_WIDE : COLS_NARROW;
            time_reg <= req.time_ms;
            tmod_reg <= '0;
        end
        else if (busy_reg)
        begin
            loc_reg  <= loc_next;
            rem_reg  <= rem_next;
            time_reg <= {time_reg[29:0], 2'b00};
            tmod_reg <= tmod_next;
        end
    end

    assign res.done = done_reg;
    assign res.quot = loc_reg;
    assign res.rem  = rem_reg;
    assign res.tmod = tmod_reg;

endmodule

### hdl/cga_text_display_controller_core.sv
// ============================================================================
// cga_text_display_controller_core
// Colour text-mode display adapter: command decode and cell request builder.
// ============================================================================
// Usage notes:
//  - request (sink): one command per request; mode, colour, CRTC index/data,
//    status read, retrace set/clear, frame start and cell.
//  - result (source): exactly one result request per command, in order.
//  - One command in flight at a time. Register writes take effect at
//    acceptance. A cell result passes through the two reads of CRTC
//    registers 14/15 from the register RAM, the start of the iterative
//    divider, the divider run (cursor location / columns, time mod 1000),
//    a wait for it to finish and the load of the output register; a
//    non-cell result goes straight to that load.
//  - request.ready rises again on the edge that loads the result, so a
//    new request is taken only once the last result has been loaded.
//  - The result sits in an output register; a stalled receiver holds it,
//    and a finished command waits in its final state until the slot frees.
//  - Reset: 80 columns, text mode, all CRTC registers and status read zero.
// ============================================================================
module cga_text_display_controller_core
    import cga_tdc_pkg::*;
#(
    parameter int CRTC_REG_COUNT = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    cga_req_if.sink   request,
    cga_res_if.source result
);

    localparam int AW = $clog2(CRTC_REG_COUNT);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD_HI = 3'd1;
    localparam logic [2:0] S_RD_LO = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;

    // adapter state
    logic       eighty_reg;
    logic       graphics_reg;
    logic       grey_reg;
    logic       hires_reg;
    logic [3:0] bg_index_reg;
    logic       intense_reg;
    logic       alt_pal_reg;
    logic [7:0] status_reg;
    logic [7:0] crtc_index_reg;

    // latched command
    logic [3:0]  cmd_reg;
    logic [4:0]  row_reg;
    logic [6:0]  col_reg;
    logic [7:0]  chr_reg;
    logic [7:0]  attr_reg;
    logic [31:0] time_reg;
    logic [7:0]  loc_hi_reg;

    // output register
    logic        out_valid_reg;
    logic [7:0]  read_data_reg;
    logic [19:0] char_address_reg;
    logic        draw_reg;
    logic [7:0]  glyph_reg;
    logic [3:0]  fg_reg;
    logic [3:0]  bg_reg;
    logic [23:0] rgb_reg;
    logic [9:0]  px_reg;
    logic [7:0]  py_reg;

    logic          accept;
    logic          slot_free;
    logic          load_out;
    logic          ram_wr_en;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [7:0]    ram_rd_data;
    div_req_t      div_req;
    div_res_t      div_res;

    // result computation
    logic [6:0]  cols;
    logic [19:0] row_off;
    logic        cursor;
    logic [7:0]  glyph_sel;
    logic [7:0]  attr_sel;
    logic        draw;
    logic [7:0]  read_data_next;
    logic [19:0] char_address_next;
    logic        draw_next;
    logic [7:0]  glyph_next;
    logic [3:0]  fg_next;
    logic [3:0]  bg_next;
    logic [23:0] rgb_next;
    logic [9:0]  px_next;
    logic [7:0]  py_next;

    assign request.ready = (state_reg == S_IDLE);
    assign accept        = request.valid && request.ready;
    assign slot_free     = !out_valid_reg || result.ready;
    assign load_out      = (state_reg == S_DONE) && slot_free;

    // index beyond the register file: write dropped
    assign ram_wr_en = accept && (request.command == CMD_CRTC_DATA) &&
                       ({1'b0, crtc_index_reg} < 9'(CRTC_REG_COUNT));
    assign ram_rd_en   = (state_reg == S_RD_HI) || (state_reg == S_RD_LO);
    assign ram_rd_addr = (state_reg == S_RD_HI) ? AW'(CRTC_LOC_HI) : AW'(CRTC_LOC_LO);

    cga_tdc_crtc_ram #(
        .DEPTH (CRTC_REG_COUNT),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ram_wr_en),
        .wr_addr (crtc_index_reg[AW-1:0]),
        .wr_data (request.data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign div_req.start   = (state_reg == S_DIV);
    assign div_req.loc     = {loc_hi_reg, ram_rd_data};
    assign div_req.eighty  = eighty_reg;
    assign div_req.time_ms = time_reg;

    cga_tdc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (request.command == CMD_CELL) ? S_RD_HI : S_DONE;
                end
            end
            S_RD_HI: state_next = S_RD_LO;
            S_RD_LO: state_next = S_DIV;
            S_DIV:   state_next = S_WAIT;
            S_WAIT:
            begin
                if (div_res.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // result of the latched command
    always_comb
    begin
        cols    = eighty_reg ? COLS_WIDE : COLS_NARROW;
        row_off = eighty_reg ? (20'({row_reg, 7'd0}) + 20'({row_reg, 5'd0}))
                             : (20'({row_reg, 6'd0}) + 20'({row_reg, 4'd0}));
        cursor  = (div_res.quot == {11'd0, row_reg}) && (div_res.rem == col_reg) &&
                  (div_res.tmod > BLINK_ON);
        glyph_sel = cursor ? CURSOR_GLYPH : chr_reg;
        attr_sel  = cursor ? {attr_reg[7:4], CURSOR_FG} : attr_reg;
        draw      = !graphics_reg && (col_reg < cols) &&
                    ({2'b00, row_reg} < TEXT_ROWS) && (glyph_sel != 8'd0);

        read_data_next    = '0;
        char_address_next = '0;
        draw_next         = 1'b0;
        glyph_next        = '0;
        fg_next           = '0;
        bg_next           = '0;
        rgb_next          = '0;
        px_next           = '0;
        py_next           = '0;
        case (cmd_reg)
            CMD_STATUS: read_data_next = status_reg;
            CMD_FRAME:  rgb_next = graphics_reg ? palette_rgb(bg_index_reg) : 24'd0;
            CMD_CELL:
            begin
                char_address_next = VIDEO_BASE + row_off + 20'({col_reg, 1'b0});
                px_next           = {col_reg, 3'b000};
                py_next           = {row_reg, 3'b000};
                if (draw)
                begin
                    draw_next  = 1'b1;
                    glyph_next = glyph_sel;
                    fg_next    = attr_sel[3:0];
                    bg_next    = attr_sel[7:4];
                    rgb_next   = palette_rgb(attr_sel[7:4]);
                end
            end
            default: ;
        endcase
    end

    // control and adapter state; register writes land at acceptance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            eighty_reg     <= 1'b1;
            graphics_reg   <= 1'b0;
            grey_reg       <= 1'b0;
            hires_reg      <= 1'b0;
            bg_index_reg   <= '0;
            intense_reg    <= 1'b0;
            alt_pal_reg    <= 1'b0;
            status_reg     <= '0;
            crtc_index_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                case (request.command)
                    CMD_MODE:
                    begin
                        eighty_reg   <= request.data[0];
                        graphics_reg <= request.data[1];
                        grey_reg     <= request.data[2];
                        hires_reg    <= request.data[4];
                    end
                    CMD_COLOUR:
                    begin
                        bg_index_reg <= request.data[3:0];
                        intense_reg  <= request.data[4];
                        alt_pal_reg  <= request.data[5];
                    end
                    CMD_CRTC_INDEX: crtc_index_reg <= request.data;
                    CMD_HRT_ON:     status_reg <= status_reg | STAT_HRT;
                    CMD_HRT_OFF:    status_reg <= status_reg & ~STAT_HRT;
                    CMD_VRT_ON:     status_reg <= status_reg | STAT_VRT;
                    CMD_VRT_OFF:    status_reg <= status_reg & ~STAT_VRT;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= request.command;
            row_reg  <= request.row;
            col_reg  <= request.column;
            chr_reg  <= request.character;
            attr_reg <= request.attribute;
            time_reg <= request.time_ms;
        end
        if (state_reg == S_RD_LO)
        begin
            loc_hi_reg <= ram_rd_data;
        end
        if (load_out)
        begin
            read_data_reg    <= read_data_next;
            char_address_reg <= char_address_next;
            draw_reg         <= draw_next;
            glyph_reg        <= glyph_next;
            fg_reg           <= fg_next;
            bg_reg           <= bg_next;
            // greyscale, high-res and palette bits are stored only
            rgb_reg          <= rgb_next | {24{grey_reg & hires_reg & intense_reg &
                                               alt_pal_reg & 1'b0}};
            px_reg           <= px_next;
            py_reg           <= py_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.read_data    = read_data_reg;
    assign result.char_address = char_address_reg;
    assign result.draw         = draw_reg;
    assign result.glyph        = glyph_reg;
    assign result.fg_color     = fg_reg;
    assign result.bg_color     = bg_reg;
    assign result.color_rgb    = rgb_reg;
    assign result.pixel_x      = px_reg;
    assign result.pixel_y      = py_reg;

endmodule

### hdl/cga_tdc_checker.sv
// ============================================================================
// cga_tdc_checker
// Port-level checks on the text display controller, bound to the top level.
// ============================================================================
module cga_tdc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [7:0]  res_read_data,
    input logic [19:0] res_char_address,
    input logic        res_draw,
    input logic [7:0]  res_glyph
);

    // a held result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // one command in flight: ready drops after each acceptance
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while busy");

    // a drawn cell never carries glyph zero
    a_draw_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_draw |-> res_glyph != 8'd0)
        else $error("drawn cell with empty glyph");

    // status byte carries only the retrace bits, and never with a cell
    a_status_bits: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_read_data != 8'd0 |->
            (res_read_data & 8'hF6) == 8'd0 && res_char_address == 20'd0 && !res_draw)
        else $error("bad status result");

endmodule

bind cga_text_display_controller_core cga_tdc_checker u_cga_tdc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (request.valid),
    .req_ready        (request.ready),
    .res_valid        (result.valid),
    .res_ready        (result.ready),
    .res_read_data    (result.read_data),
    .res_char_address (result.char_address),
    .res_draw         (result.draw),
    .res_glyph        (result.glyph)
);

### tb/tb_cga_text_display_controller_core.sv
// ============================================================================
// tb_cga_text_display_controller_core
// Self-checking bench for the colour text display controller. A directed
// table covers reset values, field extremes, every command, cursor blink,
// undrawn cells, ignored CRTC writes and the palette fix. A long random run
// follows, built mostly from cursor set-ups and cell bursts around the
// cursor. Every result request is checked against a shadow or a typed row.
// ============================================================================
module tb_cga_text_display_controller_core;
    import cga_tdc_pkg::*;

    localparam int CRTC_REGS     = 32;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int CALM_FROM     = 1600;   // no idling on either side past here
    localparam int HOLD_AT       = 600;    // long receiver hold-off
    localparam int DRAIN_AT      = 1200;   // sender waits for every result
    localparam int HOLD_CYCLES   = 400;
    localparam int TAIL_CYCLES   = 40;

    // commands the block decodes as no-ops
    localparam logic [3:0] CMD_SPARE_FIRST = 4'd11;
    localparam logic [3:0] CMD_SPARE_LAST  = 4'd15;

    localparam logic [23:0] PALETTE [16] = '{
        24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
        24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
        24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
        24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
    };

    typedef struct packed {
        logic [3:0]  command;
        logic [7:0]  data;
        logic [4:0]  row;
        logic [6:0]  column;
        logic [7:0]  character;
        logic [7:0]  attribute;
        logic [31:0] time_ms;
    } cmd_req_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [19:0] char_address;
        logic        draw;
        logic [7:0]  glyph;
        logic [3:0]  fg_color;
        logic [3:0]  bg_color;
        logic [23:0] color_rgb;
        logic [9:0]  pixel_x;
        logic [7:0]  pixel_y;
    } cell_res_t;

    typedef struct {
        cmd_req_t  req;
        bit        typed;      // expected result written in by hand
        cell_res_t res;
    } vector_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cga_req_if req_bus ();
    cga_res_if res_bus ();

    cga_text_display_controller_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_bus),
        .result  (res_bus)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // Shadow of the adapter registers
    // ------------------------------------------------------------------------
    logic [7:0] sh_crtc_idx;
    logic [7:0] sh_regs [CRTC_REGS];
    logic       sh_eighty;
    logic       sh_graphics;
    logic       sh_grey;
    logic       sh_hires;
    logic [3:0] sh_bg_idx;
    logic       sh_intense;
    logic       sh_alt;
    logic [7:0] sh_status;

    cell_res_t  expected_q [$];
    int         errors = 0;
    int         sent = 0;
    int         gap_pct = 0;
    bit         calm = 1'b0;
    bit         hold_req = 1'b0;

    // Advance the shadow by one command and return the result it should give.
    function automatic cell_res_t predict_cell(input cmd_req_t q);
        cell_res_t   r;
        int unsigned cols;
        int unsigned loc;
        int unsigned addr;
        logic [7:0]  gl;
        logic [7:0]  at;
        bit          drawn;
        r = '0;
        case (q.command)
            CMD_MODE: begin
                sh_eighty   = q.data[0];
                sh_graphics = q.data[1];
                sh_grey     = q.data[2];
                sh_hires    = q.data[4];
            end
            CMD_COLOUR: begin
                sh_bg_idx  = q.data[3:0];
                sh_intense = q.data[4];
                sh_alt     = q.data[5];
            end
            CMD_CRTC_INDEX: sh_crtc_idx = q.data;
            CMD_CRTC_DATA: begin
                // index past the register file: write dropped
                if (sh_crtc_idx < CRTC_REGS)
                    sh_regs[sh_crtc_idx] = q.data;
            end
            CMD_STATUS:  r.read_data = sh_status;
            CMD_HRT_ON:  sh_status = sh_status | STAT_HRT;
            CMD_HRT_OFF: sh_status = sh_status & ~STAT_HRT;
            CMD_VRT_ON:  sh_status = sh_status | STAT_VRT;
            CMD_VRT_OFF: sh_status = sh_status & ~STAT_VRT;
            CMD_FRAME:   r.color_rgb = sh_graphics ? PALETTE[sh_bg_idx] : 24'h000000;
            CMD_CELL: begin
                cols = sh_eighty ? COLS_WIDE : COLS_NARROW;
                loc  = {sh_regs[CRTC_LOC_HI], sh_regs[CRTC_LOC_LO]};
                gl   = q.character;
                at   = q.attribute;
                // full quotient against the row, so an off-screen cursor never hits
                if (loc / cols == q.row && loc % cols == q.column &&
                    (q.time_ms % BLINK_PERIOD) > BLINK_ON)
                begin
                    gl = CURSOR_GLYPH;
                    at = {q.attribute[7:4], CURSOR_FG};
                end
                drawn = !sh_graphics && q.column < cols && q.row < TEXT_ROWS &&
                        gl != 8'h00;
                addr = VIDEO_BASE + q.row * cols * 2 + q.column * 2;
                r.char_address = addr[19:0];
                r.pixel_x      = {q.column, 3'b000};
                r.pixel_y      = {q.row, 3'b000};
                if (drawn)
                begin
                    r.draw      = 1'b1;
                    r.glyph     = gl;
                    r.fg_color  = at[3:0];
                    r.bg_color  = at[7:4];
                    r.color_rgb = PALETTE[at[7:4]];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic cmd_req_t req_of(input logic [3:0] c, input logic [7:0] d,
                                        input logic [4:0] r, input logic [6:0] col,
                                        input logic [7:0] ch, input logic [7:0] at,
                                        input logic [31:0] t);
        cmd_req_t q;
        q = '{command: c, data: d, row: r, column: col, character: ch,
              attribute: at, time_ms: t};
        return q;
    endfunction

    // Non-cell command; the unused fields carry random junk.
    function automatic cmd_req_t bus_req(input logic [3:0] c, input logic [7:0] d);
        return req_of(c, d, 5'($urandom), 7'($urandom), 8'($urandom), 8'($urandom),
                      $urandom);
    endfunction

    function automatic cell_res_t res_of(input logic [7:0] rd, input logic [19:0] adr,
                                         input logic dr, input logic [7:0] gl,
                                         input logic [3:0] fg, input logic [3:0] bg,
                                         input logic [23:0] rgb, input logic [9:0] px,
                                         input logic [7:0] py);
        cell_res_t r;
        r = '{read_data: rd, char_address: adr, draw: dr, glyph: gl, fg_color: fg,
              bg_color: bg, color_rgb: rgb, pixel_x: px, pixel_y: py};
        return r;
    endfunction

    // Offer one request, hold it until accepted, then queue its expectation.
    task automatic issue(input cmd_req_t q, input bit typed, input cell_res_t typed_res);
        cell_res_t pred;
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.command   <= q.command;
        req_bus.data      <= q.data;
        req_bus.row       <= q.row;
        req_bus.column    <= q.column;
        req_bus.character <= q.character;
        req_bus.attribute <= q.attribute;
        req_bus.time_ms   <= q.time_ms;
        @(posedge clk);
        while (!req_bus.ready) @(posedge clk);
        // shadow always advances, even when the expectation is typed in
        pred = predict_cell(q);
        expected_q.push_back(typed ? typed_res : pred);
        sent++;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, one long hold-off on demand, none when calm
    // ------------------------------------------------------------------------
    initial
    begin
        res_bus.ready <= 1'b0;
        forever
        begin
            if (hold_req)
            begin
                res_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (calm)
            begin
                res_bus.ready <= 1'b1;
                @(posedge clk);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                res_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                res_bus.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: oldest expectation against each accepted result request
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        cell_res_t got;
        cell_res_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            got = res_of(res_bus.read_data, res_bus.char_address, res_bus.draw,
                         res_bus.glyph, res_bus.fg_color, res_bus.bg_color,
                         res_bus.color_rgb, res_bus.pixel_x, res_bus.pixel_y);
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    $display("%0t: expected rd=%h adr=%h dr=%b gl=%h fg=%h bg=%h rgb=%h x=%0d y=%0d",
                             $time, want.read_data, want.char_address, want.draw,
                             want.glyph, want.fg_color, want.bg_color, want.color_rgb,
                             want.pixel_x, want.pixel_y);
                    $display("%0t: actual   rd=%h adr=%h dr=%b gl=%h fg=%h bg=%h rgb=%h x=%0d y=%0d",
                             $time, got.read_data, got.char_address, got.draw,
                             got.glyph, got.fg_color, got.bg_color, got.color_rgb,
                             got.pixel_x, got.pixel_y);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        vector_t     tab [$];
        int unsigned cols;
        int unsigned loc;
        int          pick;
        int          n;
        logic [4:0]  r5;
        logic [6:0]  c7;
        logic [7:0]  ch;
        logic [7:0]  hi;
        logic [31:0] tm;
        bit          hold_done;
        bit          drain_done;

        req_bus.valid     <= 1'b0;
        req_bus.command   <= CMD_STATUS;
        req_bus.data      <= 8'h00;
        req_bus.row       <= 5'd0;
        req_bus.column    <= 7'd0;
        req_bus.character <= 8'h00;
        req_bus.attribute <= 8'h00;
        req_bus.time_ms   <= 32'd0;

        // shadow after reset: 80 columns, text mode, everything else clear
        sh_crtc_idx = 8'h00;
        for (int i = 0; i < CRTC_REGS; i++)
            sh_regs[i] = 8'h00;
        sh_eighty   = 1'b1;
        sh_graphics = 1'b0;
        sh_grey     = 1'b0;
        sh_hires    = 1'b0;
        sh_bg_idx   = 4'h0;
        sh_intense  = 1'b0;
        sh_alt      = 1'b0;
        sh_status   = 8'h00;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // --- directed table: typed rows are checked literally ---------------
        tab.push_back('{req_of(CMD_STATUS, 8'h00, 5'd0, 7'd0, 8'h00, 8'h00, 32'd0),
                        1'b1, res_of(8'h00, 20'h0, 1'b0, 8'h00, 4'h0, 4'h0, 24'h0, 10'd0, 8'd0)});
        tab.push_back('{req_of(CMD_FRAME, 8'h00, 5'd0, 7'd0, 8'h00, 8'h00, 32'd0),
                        1'b1, res_of(8'h00, 20'h0, 1'b0, 8'h00, 4'h0, 4'h0, 24'h0, 10'd0, 8'd0)});
        // cursor sits on 0,0 but the blink phase is off
        tab.push_back('{req_of(CMD_CELL, 8'h00, 5'd0, 7'd0, 8'h41, 8'h1E, 32'd0), 1'b1,
                        res_of(8'h00, 20'hB8000, 1'b1, 8'h41, 4'hE, 4'h1, 24'h0000AA,
                               10'd0, 8'd0)});
        // null character: not drawn, position still given
        tab.push_back('{req_of(CMD_CELL, 8'h00, 5'd0, 7'd5, 8'h00, 8'h07, 32'd501), 1'b1,
                        res_of(8'h00, 20'hB800A, 1'b0, 8'h00, 4'h0, 4'h0, 24'h0,
                               10'd40, 8'd0)});
        tab.push_back('{req_of(CMD_CELL, 8'h00, 5'd24, 7'd79, 8'hFF, 8'hFF, 32'hFFFFFFFF),
                        1'b1, res_of(8'h00, 20'hB8F9E, 1'b1, 8'hFF, 4'hF, 4'hF,
                                     24'hFFFFFF, 10'd632, 8'd192)});
        // row past the screen, column at the field limit
        tab.push_back('{req_of(CMD_CELL, 8'h00, 5'd31, 7'd127, 8'h41, 8'h1E, 32'd0), 1'b1,
                        res_of(8'h00, 20'hB945E, 1'b0, 8'h00, 4'h0, 4'h0, 24'h0,
                               10'd1016, 8'd248)});
        tab.push_back('{req_of(CMD_CELL, 8'h00, 5'd0, 7'd80, 8'h41, 8'h1E, 32'd0),
                        1'b0, '0});
        tab.push_back('{bus_req(CMD_HRT_ON, 8'h00), 1'b0, '0});
        tab.push_back('{bus_req(CMD_VRT_ON, 8'h00), 1'b0, '0});
        tab.push_back('{req_of(CMD_STATUS, 8'h00, 5'd0, 7'd0, 8'h00, 8'h00, 32'd0),
                        1'b1, res_of(8'h09, 20'h0, 1'b0, 8'h00, 4'h0, 4'h0, 24'h0, 10'd0, 8'd0)});
        tab.push_back('{bus_req(CMD_HRT_OFF, 8'h00), 1'b0, '0});
        tab.push_back('{req_of(CMD_STATUS, 8'h00, 5'd0, 7'd0, 8'h00, 8'h00, 32'd0),
                        1'b1, res_of(8'h08, 20'h0, 1'b0, 8'h00, 4'h0, 4'h0, 24'h0, 10'd0, 8'd0)});
        tab.push_back('{bus_req(CMD_VRT_OFF, 8'h00), 1'b0, '0});
        // cursor at location 81: row 1 column 1 in 80 columns
        tab.push_back('{bus_req(CMD_CRTC_INDEX, 8'(CRTC_LOC_HI)), 1'b0, '0});
        tab.push_back('{bus_req(CMD_CRTC_DATA, 8'h00), 1'b0, '0});
        tab.push_back('{bus_req(CMD_CRTC_INDEX, 8'(CRTC_LOC_LO)), 1'b0, '0});
        tab.push_back('{bus_req(CMD_CRTC_DATA, 8'h51), 1'b0, '0});
        tab.push_back('{req_of(CMD_CELL, 8'h00, 5'd1, 7'd1, 8'h41, 8'h2C, 32'd501),
                        1'b0, '0});
        tab.push_back('{req_of(CMD_CELL, 8'h00, 5'd1, 7'd1, 8'h41, 8'h2C, 32'd500),
                        1'b0, '0});
        // out-of-range CRTC write must not land anywhere
        tab.push_back('{bus_req(CMD_CRTC_INDEX, 8'd200), 1'b0, '0});
        tab.push_back('{bus_req(CMD_CRTC_DATA, 8'hAA), 1'b0, '0});
        // 40 columns: same location becomes row 2 column 1; blink beats null char
        tab.push_back('{bus_req(CMD_MODE, 8'h00), 1'b0, '0});
        tab.push_back('{req_of(CMD_CELL, 8'h00, 5'd2, 7'd1, 8'h00, 8'h5A, 32'd999),
                        1'b0, '0});
        // graphics mode: frame takes the background colour, cells are not drawn
        tab.push_back('{bus_req(CMD_COLOUR, 8'h3C), 1'b0, '0});
        tab.push_back('{bus_req(CMD_MODE, 8'h16), 1'b0, '0});
        tab.push_back('{req_of(CMD_FRAME, 8'h00, 5'd0, 7'd0, 8'h00, 8'h00, 32'd0),
                        1'b1, res_of(8'h00, 20'h0, 1'b0, 8'h00, 4'h0, 4'h0, 24'hFF5555,
                                     10'd0, 8'd0)});
        // light green corrected to 55FF55
        tab.push_back('{bus_req(CMD_COLOUR, 8'h0A), 1'b0, '0});
        tab.push_back('{req_of(CMD_FRAME, 8'h00, 5'd0, 7'd0, 8'h00, 8'h00, 32'd0),
                        1'b1, res_of(8'h00, 20'h0, 1'b0, 8'h00, 4'h0, 4'h0, 24'h55FF55,
                                     10'd0, 8'd0)});
        tab.push_back('{req_of(CMD_CELL, 8'h00, 5'd3, 7'd3, 8'h41, 8'h1E, 32'd0),
                        1'b0, '0});
        tab.push_back('{bus_req(CMD_SPARE_FIRST, 8'h00), 1'b0, '0});
        tab.push_back('{bus_req(CMD_SPARE_LAST, 8'hFF), 1'b0, '0});
        tab.push_back('{bus_req(CMD_MODE, 8'h01), 1'b0, '0});

        gap_pct = 20;
        foreach (tab[i])
            issue(tab[i].req, tab[i].typed, tab[i].res);

        // --- random run ----------------------------------------------------
        sent       = 0;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= CALM_FROM)
                calm = 1'b1;
            if (!hold_done && sent >= HOLD_AT)
            begin
                // receiver stops; sender keeps offering so the input backs up
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!drain_done && sent >= DRAIN_AT)
            begin
                req_bus.valid <= 1'b0;
                while (expected_q.size() != 0) @(posedge clk);
                drain_done = 1'b1;
            end

            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 15;
                default: gap_pct = 40;
            endcase

            pick = $urandom_range(0, 9);
            if (pick <= 1)
            begin
                // cursor set-up; mostly a location on the screen
                hi = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
                issue(bus_req(CMD_CRTC_INDEX, 8'(CRTC_LOC_HI)), 1'b0, '0);
                issue(bus_req(CMD_CRTC_DATA, hi), 1'b0, '0);
                issue(bus_req(CMD_CRTC_INDEX, 8'(CRTC_LOC_LO)), 1'b0, '0);
                issue(bus_req(CMD_CRTC_DATA, 8'($urandom)), 1'b0, '0);
            end
            else if (pick <= 4)
            begin
                n = $urandom_range(1, 8);
                repeat (n)
                begin
                    cols = sh_eighty ? COLS_WIDE : COLS_NARROW;
                    loc  = {sh_regs[CRTC_LOC_HI], sh_regs[CRTC_LOC_LO]};
                    if ($urandom_range(0, 1) == 1 && loc / cols < 32)
                    begin
                        r5 = 5'(loc / cols);
                        c7 = 7'(loc % cols);
                    end
                    else if ($urandom_range(0, 4) == 0)
                    begin
                        r5 = 5'($urandom);
                        c7 = 7'($urandom);
                    end
                    else
                    begin
                        r5 = 5'($urandom_range(0, TEXT_ROWS - 1));
                        c7 = 7'($urandom_range(0, cols - 1));
                    end
                    ch = ($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom);
                    // half the time close to the blink threshold
                    tm = ($urandom_range(0, 1) == 1) ? $urandom :
                         $urandom_range(0, 4000000) * 1000 + $urandom_range(495, 505);
                    issue(req_of(CMD_CELL, 8'($urandom), r5, c7, ch, 8'($urandom), tm),
                          1'b0, '0);
                end
            end
            else if (pick == 5)
            begin
                // mode write mostly stays in text mode
                issue(bus_req(CMD_MODE, ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                              (8'($urandom) & 8'hFD)), 1'b0, '0);
                issue(bus_req(CMD_COLOUR, 8'($urandom)), 1'b0, '0);
            end
            else if (pick == 6)
            begin
                n = $urandom_range(2, 6);
                repeat (n)
                    issue(bus_req(4'($urandom_range(CMD_STATUS, CMD_VRT_OFF)), 8'($urandom)),
                          1'b0, '0);
            end
            else if (pick == 7)
                issue(bus_req(CMD_FRAME, 8'($urandom)), 1'b0, '0);
            else if (pick == 8)
            begin
                // noise, including spare commands and wild CRTC indexes
                issue(bus_req(4'($urandom_range(CMD_MODE, CMD_SPARE_LAST)), 8'($urandom)),
                      1'b0, '0);
                issue(bus_req(CMD_CRTC_INDEX, 8'($urandom)), 1'b0, '0);
                issue(bus_req(CMD_CRTC_DATA, 8'($urandom)), 1'b0, '0);
            end
            else
            begin
                issue(bus_req(CMD_CRTC_INDEX, 8'($urandom_range(0, CRTC_REGS - 1))), 1'b0, '0);
                issue(bus_req(CMD_CRTC_DATA, 8'($urandom)), 1'b0, '0);
            end
        end

        // --- drain and report ----------------------------------------------
        req_bus.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: well past the slowest legal run.
    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### cga_text_display_controller_core.f
hdl/cga_tdc_pkg.sv
hdl/cga_tdc_if.sv
hdl/cga_tdc_crtc_ram.sv
hdl/cga_tdc_div.sv
hdl/cga_text_display_controller_core.sv
hdl/cga_tdc_checker.sv
tb/tb_cga_text_display_controller_core.sv
